@@ hw/rtl/gtscp_pkg.sv @@
// Shared types, codes and widths of the generation-tagged counter pool.
package gtscp_pkg;

  // Default sizing of the pool
  localparam int unsigned POOL_SIZE_DEFAULT   = 256;
  localparam int unsigned MAX_WAITERS_DEFAULT = 255;

  // Fixed field widths
  localparam int unsigned IDX_IN_W = 8;
  localparam int unsigned GEN_W    = 32;
  localparam int unsigned INIT_W   = 32;
  localparam int unsigned CNT_W    = 31;
  localparam int unsigned WOKEN_W  = 8;
  // Width that holds any slot_index as well as the largest pool size
  localparam int unsigned IDX_CHK_W = 17;

  typedef enum logic [1:0] {
    OP_ACQUIRE    = 2'd0,
    OP_ADD_WAITER = 2'd1,
    OP_DECREMENT  = 2'd2,
    OP_FREE       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_STALE     = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_INIT  = 3'd4,
    ST_UNDERFLOW = 3'd5,
    ST_OVERFLOW  = 3'd6
  } status_e;

  typedef struct packed {
    logic pop;
    logic push;
  } queue_ctrl_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } slot_ctrl_t;

endpackage

@@ hw/rtl/gtscp_in_if.sv @@
// Request channel: one pool operation per transfer.
interface gtscp_in_if;
  import gtscp_pkg::*;

  logic                valid;
  logic                ready;
  op_e                 opcode;
  logic                id_valid;
  logic [IDX_IN_W-1:0] slot_index;
  logic [GEN_W-1:0]    handle_generation;
  logic [INIT_W-1:0]   initial_value;

  modport source (
    output valid, opcode, id_valid, slot_index, handle_generation, initial_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, id_valid, slot_index, handle_generation, initial_value,
    output ready
  );
endinterface

@@ hw/rtl/gtscp_out_if.sv @@
// Response channel: one result per transfer.
interface gtscp_out_if;
  import gtscp_pkg::*;

  logic                valid;
  logic                ready;
  status_e             status;
  logic [IDX_IN_W-1:0] result_index;
  logic [GEN_W-1:0]    result_generation;
  logic [CNT_W-1:0]    counter_value;
  logic                must_wait;
  logic [WOKEN_W-1:0]  woken_waiters;

  modport source (
    output valid, status, result_index, result_generation, counter_value,
           must_wait, woken_waiters,
    input  ready
  );

  modport sink (
    input  valid, status, result_index, result_generation, counter_value,
           must_wait, woken_waiters,
    output ready
  );
endinterface

@@ hw/rtl/gtscp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gtscp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hw/rtl/gtscp_free_queue.sv @@
// Free-id ring queue: pointers, fill count and a prefetched head entry.
module gtscp_free_queue #(
  parameter int unsigned POOL_SIZE = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_en_i,
  input  logic [$clog2(POOL_SIZE)-1:0]   clear_addr_i,
  input  gtscp_pkg::queue_ctrl_t         ctrl_i,
  input  logic [$clog2(POOL_SIZE)-1:0]   push_id_i,
  output logic [$clog2(POOL_SIZE)-1:0]   front_o,
  output logic [$clog2(POOL_SIZE+1)-1:0] fill_o
);
  import gtscp_pkg::*;

  localparam int unsigned IDX_W  = $clog2(POOL_SIZE);
  localparam int unsigned FILL_W = $clog2(POOL_SIZE + 1);

  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  wdata;
  logic [IDX_W-1:0]  rdata;
  logic              fwd_q;
  logic [IDX_W-1:0]  fwd_data_q;

  function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(POOL_SIZE - 1)) ? '0 : p + 1'b1;
  endfunction

  // Advance pointers and fill on a pop or a push
  always_comb begin
    head_d = ctrl_i.pop  ? next_pos(head_q) : head_q;
    tail_d = ctrl_i.push ? next_pos(tail_q) : tail_q;
    fill_d = fill_q;
    if (ctrl_i.pop) begin
      fill_d = fill_q - 1'b1;
    end else if (ctrl_i.push) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= FILL_W'(POOL_SIZE);
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // Load identity ids during the clearing pass, else push at the tail
  assign we    = clear_en_i | ctrl_i.push;
  assign waddr = clear_en_i ? clear_addr_i : tail_q;
  assign wdata = clear_en_i ? clear_addr_i : push_id_i;

  gtscp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_SIZE)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (1'b1),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  // Bypass a write that lands on the entry being prefetched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we && (waddr == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata;
  end

  assign front_o = fwd_q ? fwd_data_q : rdata;
  assign fill_o  = fill_q;
endmodule

@@ hw/rtl/gtscp_slot_store.sv @@
// Per-slot count, generation and waiter memories with write bypass.
module gtscp_slot_store #(
  parameter int unsigned POOL_SIZE   = 256,
  parameter int unsigned MAX_WAITERS = 255
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gtscp_pkg::slot_ctrl_t              ctrl_i,
  input  logic                               clear_en_i,
  input  logic [$clog2(POOL_SIZE)-1:0]       clear_addr_i,
  input  logic [$clog2(POOL_SIZE)-1:0]       raddr_i,
  input  logic [$clog2(POOL_SIZE)-1:0]       waddr_i,
  input  logic [gtscp_pkg::CNT_W-1:0]        wcnt_i,
  input  logic [gtscp_pkg::GEN_W-1:0]        wgen_i,
  input  logic [$clog2(MAX_WAITERS+1)-1:0]   wwt_i,
  output logic [gtscp_pkg::CNT_W-1:0]        rcnt_o,
  output logic [gtscp_pkg::GEN_W-1:0]        rgen_o,
  output logic [$clog2(MAX_WAITERS+1)-1:0]   rwt_o
);
  import gtscp_pkg::*;

  localparam int unsigned IDX_W = $clog2(POOL_SIZE);
  localparam int unsigned WT_W  = $clog2(MAX_WAITERS + 1);

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [CNT_W-1:0] wcnt, ram_cnt, fwd_cnt_q;
  logic [GEN_W-1:0] wgen, ram_gen, fwd_gen_q;
  logic [WT_W-1:0]  wwt,  ram_wt,  fwd_wt_q;
  logic             fwd_q;

  // Zero every slot during the clearing pass
  assign we    = clear_en_i | ctrl_i.wr_en;
  assign waddr = clear_en_i ? clear_addr_i : waddr_i;
  assign wcnt  = clear_en_i ? '0 : wcnt_i;
  assign wgen  = clear_en_i ? '0 : wgen_i;
  assign wwt   = clear_en_i ? '0 : wwt_i;

  gtscp_ram #(.WIDTH(CNT_W), .DEPTH(POOL_SIZE)) u_cnt_ram (
    .clk_i (clk_i), .we_i (we), .waddr_i (waddr), .wdata_i (wcnt),
    .re_i (ctrl_i.rd_en), .raddr_i (raddr_i), .rdata_o (ram_cnt)
  );

  gtscp_ram #(.WIDTH(GEN_W), .DEPTH(POOL_SIZE)) u_gen_ram (
    .clk_i (clk_i), .we_i (we), .waddr_i (waddr), .wdata_i (wgen),
    .re_i (ctrl_i.rd_en), .raddr_i (raddr_i), .rdata_o (ram_gen)
  );

  gtscp_ram #(.WIDTH(WT_W), .DEPTH(POOL_SIZE)) u_wt_ram (
    .clk_i (clk_i), .we_i (we), .waddr_i (waddr), .wdata_i (wwt),
    .re_i (ctrl_i.rd_en), .raddr_i (raddr_i), .rdata_o (ram_wt)
  );

  // Capture a same-edge write to the slot being read; hold while the read holds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (ctrl_i.rd_en) begin
      fwd_q <= we && (waddr == raddr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      fwd_cnt_q <= wcnt;
      fwd_gen_q <= wgen;
      fwd_wt_q  <= wwt;
    end
  end

  assign rcnt_o = fwd_q ? fwd_cnt_q : ram_cnt;
  assign rgen_o = fwd_q ? fwd_gen_q : ram_gen;
  assign rwt_o  = fwd_q ? fwd_wt_q  : ram_wt;
endmodule

@@ hw/rtl/generation_tagged_sync_counter_pool_unit.sv @@
// Top level of the generation-tagged completion counter pool.
//
//   channel   | role   | carries
//   ----------+--------+------------------------------------------------------
//   item_i    | sink   | opcode, id_valid, slot_index, handle_generation,
//             |        | initial_value
//   result_o  | source | status, result_index, result_generation,
//             |        | counter_value, must_wait, woken_waiters
//
// A transfer on item_i is registered in the execute stage with its slot read;
// the execute stage does the update and writes back as its result moves into
// the output register. A new item is taken every cycle unless the output stalls,
// but an item after an acquire or a free waits for the free-id queue head
// prefetch. After reset a clearing pass over every slot loads the slot and queue
// memories; item_i.ready stays low meanwhile. A stalled result holds in the
// output register while one more item is taken into the execute stage.
module generation_tagged_sync_counter_pool_unit #(
  parameter int unsigned POOL_SIZE   = gtscp_pkg::POOL_SIZE_DEFAULT,
  parameter int unsigned MAX_WAITERS = gtscp_pkg::MAX_WAITERS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtscp_in_if.sink    item_i,
  gtscp_out_if.source result_o
);
  import gtscp_pkg::*;

  localparam int unsigned IDX_W  = $clog2(POOL_SIZE);
  localparam int unsigned FILL_W = $clog2(POOL_SIZE + 1);
  localparam int unsigned WT_W   = $clog2(MAX_WAITERS + 1);

  // Clearing pass
  logic             clearing_q;
  logic [IDX_W-1:0] clr_q;

  // Execute stage registers
  logic                s1_valid_q;
  op_e                 s1_op_q;
  logic                s1_id_valid_q;
  logic [IDX_IN_W-1:0] s1_idx_q;
  logic [GEN_W-1:0]    s1_hgen_q;
  logic [INIT_W-1:0]   s1_init_q;
  logic [IDX_W-1:0]    s1_acq_id_q;

  // Output register
  logic                out_valid_q;
  status_e             out_status_q;
  logic [IDX_IN_W-1:0] out_index_q;
  logic [GEN_W-1:0]    out_gen_q;
  logic [CNT_W-1:0]    out_cnt_q;
  logic                out_wait_q;
  logic [WOKEN_W-1:0]  out_woken_q;

  // Handshake and store interfaces
  logic              accept;
  logic              s1_fire;
  logic              s1_queue_op;
  logic [IDX_W-1:0]  q_front;
  logic [FILL_W-1:0] q_fill;
  queue_ctrl_t       q_ctrl;
  logic [IDX_W-1:0]  q_push_id;
  slot_ctrl_t        s_ctrl;
  logic [IDX_W-1:0]  s_raddr;
  logic [IDX_W-1:0]  s_waddr;
  logic [CNT_W-1:0]  s_rcnt, s_wcnt;
  logic [GEN_W-1:0]  s_rgen, s_wgen;
  logic [WT_W-1:0]   s_rwt,  s_wwt;

  // Execute results
  logic                wr_req;
  logic                pop_req;
  logic                push_req;
  status_e             status_d;
  logic [IDX_IN_W-1:0] index_d;
  logic [GEN_W-1:0]    gen_d;
  logic [CNT_W-1:0]    cnt_d;
  logic                wait_d;
  logic [WOKEN_W-1:0]  woken_d;
  logic                invalid;
  logic                stale;
  logic [CNT_W-1:0]    cnt_dec;

  // Step the clearing pass once over every slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == IDX_W'(POOL_SIZE - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Handshake
  assign s1_fire     = s1_valid_q && (!out_valid_q || result_o.ready);
  assign s1_queue_op = (s1_op_q == OP_ACQUIRE) || (s1_op_q == OP_FREE);
  assign item_i.ready = !clearing_q && (!s1_valid_q || (s1_fire && !s1_queue_op));
  assign accept       = item_i.valid && item_i.ready;

  // Read the slot an item names; an acquire reads the queue head id
  assign s_raddr = (item_i.opcode == OP_ACQUIRE) ? q_front : IDX_W'(item_i.slot_index);

  // Load the execute stage on a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= item_i.opcode;
      s1_id_valid_q <= item_i.id_valid;
      s1_idx_q      <= item_i.slot_index;
      s1_hgen_q     <= item_i.handle_generation;
      s1_init_q     <= item_i.initial_value;
      s1_acq_id_q   <= q_front;
    end
  end

  // Check the handle against the slot
  assign invalid = !s1_id_valid_q ||
                   ({{(IDX_CHK_W - IDX_IN_W){1'b0}}, s1_idx_q} >= IDX_CHK_W'(POOL_SIZE));
  assign stale   = (s_rgen != s1_hgen_q);
  assign cnt_dec = s_rcnt - 1'b1;

  // Execute one operation on the slot and queue
  always_comb begin
    wr_req   = 1'b0;
    pop_req  = 1'b0;
    push_req = 1'b0;
    s_wcnt   = s_rcnt;
    s_wgen   = s_rgen;
    s_wwt    = s_rwt;
    status_d = ST_OK;
    index_d  = '0;
    gen_d    = '0;
    cnt_d    = '0;
    wait_d   = 1'b0;
    woken_d  = '0;
    case (s1_op_q)
      OP_ACQUIRE: begin
        if ((s1_init_q == '0) || s1_init_q[INIT_W-1]) begin
          status_d = ST_BAD_INIT;
        end else if (q_fill == '0) begin
          status_d = ST_EMPTY;
        end else begin
          pop_req = 1'b1;
          wr_req  = 1'b1;
          s_wcnt  = s1_init_q[CNT_W-1:0];
          s_wwt   = '0;
          s_wgen  = s_rgen + 1'b1;
          index_d = IDX_IN_W'(s1_acq_id_q);
          gen_d   = s_rgen + 1'b1;
          cnt_d   = s1_init_q[CNT_W-1:0];
        end
      end
      OP_ADD_WAITER: begin
        if (invalid) begin
          status_d = ST_INVALID;
        end else if (stale) begin
          status_d = ST_STALE;
        end else if (s_rcnt != '0) begin
          if (s_rwt >= WT_W'(MAX_WAITERS)) begin
            status_d = ST_OVERFLOW;
          end else begin
            wr_req = 1'b1;
            s_wwt  = s_rwt + 1'b1;
            wait_d = 1'b1;
            cnt_d  = s_rcnt;
          end
        end
      end
      OP_DECREMENT: begin
        if (invalid) begin
          status_d = ST_INVALID;
        end else if (stale) begin
          status_d = ST_STALE;
        end else if (s_rcnt == '0) begin
          status_d = ST_UNDERFLOW;
        end else begin
          wr_req = 1'b1;
          s_wcnt = cnt_dec;
          cnt_d  = cnt_dec;
          if (cnt_dec == '0) begin
            s_wwt   = '0;
            woken_d = (16'(s_rwt) > 16'd255) ? {WOKEN_W{1'b1}} : WOKEN_W'(s_rwt);
          end
        end
      end
      OP_FREE: begin
        if (invalid) begin
          status_d = ST_INVALID;
        end else if (stale) begin
          status_d = ST_STALE;
        end else if (q_fill == FILL_W'(POOL_SIZE)) begin
          status_d = ST_OVERFLOW;
        end else begin
          push_req = 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Commit writes only when the result moves on
  assign s_waddr      = (s1_op_q == OP_ACQUIRE) ? s1_acq_id_q : IDX_W'(s1_idx_q);
  assign s_ctrl.rd_en = accept;
  assign s_ctrl.wr_en = s1_fire && wr_req;
  assign q_ctrl.pop   = s1_fire && pop_req;
  assign q_ctrl.push  = s1_fire && push_req;
  assign q_push_id    = IDX_W'(s1_idx_q);

  gtscp_slot_store #(
    .POOL_SIZE   (POOL_SIZE),
    .MAX_WAITERS (MAX_WAITERS)
  ) u_slot_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (s_ctrl),
    .clear_en_i   (clearing_q),
    .clear_addr_i (clr_q),
    .raddr_i      (s_raddr),
    .waddr_i      (s_waddr),
    .wcnt_i       (s_wcnt),
    .wgen_i       (s_wgen),
    .wwt_i        (s_wwt),
    .rcnt_o       (s_rcnt),
    .rgen_o       (s_rgen),
    .rwt_o        (s_rwt)
  );

  gtscp_free_queue #(
    .POOL_SIZE (POOL_SIZE)
  ) u_free_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_en_i   (clearing_q),
    .clear_addr_i (clr_q),
    .ctrl_i       (q_ctrl),
    .push_id_i    (q_push_id),
    .front_o      (q_front),
    .fill_o       (q_fill)
  );

  // Hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_status_q <= status_d;
      out_index_q  <= index_d;
      out_gen_q    <= gen_d;
      out_cnt_q    <= cnt_d;
      out_wait_q   <= wait_d;
      out_woken_q  <= woken_d;
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.status            = out_status_q;
  assign result_o.result_index      = out_index_q;
  assign result_o.result_generation = out_gen_q;
  assign result_o.counter_value     = out_cnt_q;
  assign result_o.must_wait         = out_wait_q;
  assign result_o.woken_waiters     = out_woken_q;
endmodule
